@@ sv/hpcs_pkg.sv @@
package hpcs_pkg;

    localparam int TEMP_W  = 12;
    localparam int TIMER_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [TIMER_W-1:0]       timer_t;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_STOP   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        FAN_OFF  = 2'd0,
        FAN_LOW  = 2'd1,
        FAN_HIGH = 2'd2
    } fan_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUTDOOR_LOW_SPEED_TEMP  = 3'd0,
        REG_OUTDOOR_HIGH_SPEED_TEMP = 3'd1,
        REG_INDOOR_SPEED_TEMP       = 3'd2,
        REG_DEFROST_START_TEMP      = 3'd3,
        REG_DEFROST_END_TEMP        = 3'd4,
        REG_DEFROST_HOLDOFF_SECONDS = 3'd5,
        REG_DEFROST_MAX_SECONDS     = 3'd6,
        REG_DRAIN_SECONDS           = 3'd7
    } cfg_idx_t;

    localparam logic signed [TEMP_W:0] IN_FAN_HYST = 13'sd3;

    // fields listed from the highest bit down
    typedef struct packed {
        logic [5:0] pad;
        logic       drain_active;
        logic       defrost_active;
        logic [1:0] mode_code;
        logic       compressor_on;
        logic       valve_on;
        logic [1:0] indoor_fan_speed;
        logic [1:0] outdoor_fan_speed;
    } result_t;

endpackage

@@ sv/heat_pump_cooling_sequencer.sv @@
// Cooling sequencer for a heat pump. Each transfer on the input stream is an update
// (three coil temperatures in signed tenths of a degree), a one second tick, or a stop,
// selected by s_tuser; every input transfer yields exactly one result transfer carrying
// fan speeds, relay states and the current mode. The whole decision for one item is
// made combinationally from the state registers, so the block takes one item per
// clock; results pass through an output register backed by a one-entry skid register,
// and the input only stalls once both are full. The user must write thresholds and timeouts
// via the configuration port only while the block is idle; the block does not enforce it.
module heat_pump_cooling_sequencer #(
    parameter int VALVE_DELAY_SECONDS      = 60,
    parameter int COMPRESSOR_DELAY_SECONDS = 180
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // outdoor_coil_temp, indoor_coil_temp, indoor_exchanger_temp, zero fill
    input  logic [39:0]                        s_tdata,
    // command
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // outdoor_fan_speed, indoor_fan_speed, valve_on, compressor_on, mode_code,
    // defrost_active, drain_active, zero fill
    output logic [15:0]                        m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [hpcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hpcs_pkg::CFG_W-1:0]         cfg_wdata
);
    import hpcs_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_COOL    = 2'd1,
        MODE_DEFROST = 2'd2,
        MODE_DRAIN   = 2'd3
    } mode_t;

    localparam timer_t VALVE_DELAY = TIMER_W'(VALVE_DELAY_SECONDS);
    localparam timer_t COMP_DELAY  = TIMER_W'(COMPRESSOR_DELAY_SECONDS);

    temp_t  out_low_reg, out_high_reg, in_speed_reg, dfr_start_reg, dfr_end_reg;
    timer_t holdoff_sec_reg, dfr_max_reg, drain_sec_reg;

    mode_t  mode_reg, mode_next;
    logic   out_mem_reg, out_mem_next, in_mem_reg, in_mem_next;
    fan_t   out_fan_reg, out_fan_next, in_fan_reg, in_fan_next;
    logic   valve_reg, valve_next, comp_reg, comp_next;
    timer_t valve_tmr_reg, valve_tmr_next, comp_tmr_reg, comp_tmr_next;
    timer_t hold_tmr_reg, hold_tmr_next, dfr_tmr_reg, dfr_tmr_next;
    timer_t drain_tmr_reg, drain_tmr_next;

    result_t result;
    result_t out_data_reg, skid_data_reg;
    logic    out_vld_reg, skid_vld_reg;

    temp_t t_out, t_in, t_exch;
    logic signed [TEMP_W:0] in_hi, in_lo, t_in_x;
    logic in_fire;

    assign t_out  = temp_t'(s_tdata[11:0]);
    assign t_in   = temp_t'(s_tdata[23:12]);
    assign t_exch = temp_t'(s_tdata[35:24]);
    assign t_in_x = {t_in[TEMP_W-1], t_in};
    assign in_hi  = {in_speed_reg[TEMP_W-1], in_speed_reg} + IN_FAN_HYST;
    assign in_lo  = {in_speed_reg[TEMP_W-1], in_speed_reg} - IN_FAN_HYST;

    assign s_tready = !skid_vld_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    function automatic timer_t sat_inc(input timer_t t);
        return (t == '1) ? t : t + 1'b1;
    endfunction

    always_comb begin
        mode_next      = mode_reg;
        out_mem_next   = out_mem_reg;
        in_mem_next    = in_mem_reg;
        out_fan_next   = out_fan_reg;
        in_fan_next    = in_fan_reg;
        valve_next     = valve_reg;
        comp_next      = comp_reg;
        valve_tmr_next = valve_tmr_reg;
        comp_tmr_next  = comp_tmr_reg;
        hold_tmr_next  = hold_tmr_reg;
        dfr_tmr_next   = dfr_tmr_reg;
        drain_tmr_next = drain_tmr_reg;
        case (s_tuser)
            CMD_UPDATE: begin
                if (mode_reg == MODE_IDLE) begin
                    mode_next      = MODE_COOL;
                    valve_tmr_next = '0;
                end
                unique case (mode_next)
                    MODE_COOL: begin
                        if (t_out >= out_high_reg) begin
                            out_fan_next = FAN_HIGH;
                            out_mem_next = 1'b1;
                        end else if (t_out <= out_low_reg) begin
                            out_fan_next = FAN_LOW;
                            out_mem_next = 1'b0;
                        end else begin
                            out_fan_next = out_mem_reg ? FAN_HIGH : FAN_LOW;
                        end
                        if (t_in_x >= in_hi) begin
                            in_fan_next = FAN_HIGH;
                            in_mem_next = 1'b1;
                        end else if (t_in_x <= in_lo) begin
                            in_fan_next = FAN_LOW;
                            in_mem_next = 1'b0;
                        end else begin
                            in_fan_next = in_mem_reg ? FAN_HIGH : FAN_LOW;
                        end
                        if (!valve_reg && valve_tmr_next >= VALVE_DELAY) begin
                            valve_next    = 1'b1;
                            comp_tmr_next = '0;
                        end
                        if (!comp_reg && valve_next && comp_tmr_next >= COMP_DELAY) begin
                            comp_next     = 1'b1;
                            hold_tmr_next = '0;
                        end
                        if (comp_next && t_exch <= dfr_start_reg
                                && hold_tmr_next >= holdoff_sec_reg) begin
                            mode_next    = MODE_DEFROST;
                            dfr_tmr_next = '0;
                        end
                    end
                    MODE_DEFROST: begin
                        out_fan_next = FAN_OFF;
                        in_fan_next  = FAN_OFF;
                        valve_next   = 1'b0;
                        comp_next    = 1'b0;
                        if (dfr_tmr_reg >= dfr_max_reg || t_exch >= dfr_end_reg) begin
                            mode_next      = MODE_DRAIN;
                            drain_tmr_next = '0;
                        end
                    end
                    MODE_DRAIN: begin
                        if (drain_tmr_reg >= drain_sec_reg) begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_TICK: begin
                valve_tmr_next = sat_inc(valve_tmr_reg);
                comp_tmr_next  = sat_inc(comp_tmr_reg);
                hold_tmr_next  = sat_inc(hold_tmr_reg);
                dfr_tmr_next   = sat_inc(dfr_tmr_reg);
                drain_tmr_next = sat_inc(drain_tmr_reg);
            end
            CMD_STOP: begin
                out_fan_next = FAN_OFF;
                in_fan_next  = FAN_OFF;
                valve_next   = 1'b0;
                comp_next    = 1'b0;
                out_mem_next = 1'b1;
                in_mem_next  = 1'b1;
                mode_next    = MODE_IDLE;
            end
            default: ;
        endcase

        result                   = '0;
        result.outdoor_fan_speed = out_fan_next;
        result.indoor_fan_speed  = in_fan_next;
        result.valve_on          = valve_next;
        result.compressor_on     = comp_next;
        result.mode_code         = mode_next;
        result.defrost_active    = (mode_next == MODE_DEFROST);
        result.drain_active      = (mode_next == MODE_DRAIN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_low_reg     <= 12'sd250;
            out_high_reg    <= 12'sd350;
            in_speed_reg    <= 12'sd240;
            dfr_start_reg   <= -12'sd50;
            dfr_end_reg     <= 12'sd100;
            holdoff_sec_reg <= 16'd1800;
            dfr_max_reg     <= 16'd600;
            drain_sec_reg   <= 16'd120;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_OUTDOOR_LOW_SPEED_TEMP:  out_low_reg     <= temp_t'(cfg_wdata[11:0]);
                REG_OUTDOOR_HIGH_SPEED_TEMP: out_high_reg    <= temp_t'(cfg_wdata[11:0]);
                REG_INDOOR_SPEED_TEMP:       in_speed_reg    <= temp_t'(cfg_wdata[11:0]);
                REG_DEFROST_START_TEMP:      dfr_start_reg   <= temp_t'(cfg_wdata[11:0]);
                REG_DEFROST_END_TEMP:        dfr_end_reg     <= temp_t'(cfg_wdata[11:0]);
                REG_DEFROST_HOLDOFF_SECONDS: holdoff_sec_reg <= cfg_wdata;
                REG_DEFROST_MAX_SECONDS:     dfr_max_reg     <= cfg_wdata;
                REG_DRAIN_SECONDS:           drain_sec_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            out_mem_reg   <= 1'b1;
            in_mem_reg    <= 1'b1;
            out_fan_reg   <= FAN_OFF;
            in_fan_reg    <= FAN_OFF;
            valve_reg     <= 1'b0;
            comp_reg      <= 1'b0;
            valve_tmr_reg <= '0;
            comp_tmr_reg  <= '0;
            hold_tmr_reg  <= '0;
            dfr_tmr_reg   <= '0;
            drain_tmr_reg <= '0;
        end else if (in_fire) begin
            mode_reg      <= mode_next;
            out_mem_reg   <= out_mem_next;
            in_mem_reg    <= in_mem_next;
            out_fan_reg   <= out_fan_next;
            in_fan_reg    <= in_fan_next;
            valve_reg     <= valve_next;
            comp_reg      <= comp_next;
            valve_tmr_reg <= valve_tmr_next;
            comp_tmr_reg  <= comp_tmr_next;
            hold_tmr_reg  <= hold_tmr_next;
            dfr_tmr_reg   <= dfr_tmr_next;
            drain_tmr_reg <= drain_tmr_next;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_tready) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg <= in_fire;
            end
        end else if (in_fire) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || m_tready) begin
            out_data_reg <= skid_vld_reg ? skid_data_reg : result;
        end else if (in_fire) begin
            skid_data_reg <= result;
        end
    end

endmodule
